// ----- hdl/indexed_pixel_palette_expander_unit_assert.svh -----
// Assertion shorthands for the palette expander checkers.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef INDEXED_PIXEL_PALETTE_EXPANDER_UNIT_ASSERT_SVH
`define INDEXED_PIXEL_PALETTE_EXPANDER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define IPPE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define IPPE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/ippe_pkg.sv -----
`default_nettype none

package ippe_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int OUT_DEPTH   = 2;
    localparam int ROW_WIDTH_W = 13;
    localparam int CFG_DATA_W  = 13;

    typedef logic [0:0] cfg_idx_t;
    localparam cfg_idx_t CFG_DEPTH_MODE = 1'd0;
    localparam cfg_idx_t CFG_ROW_WIDTH  = 1'd1;

    typedef logic [1:0] mode_t;
    localparam mode_t MODE_BIT1 = 2'd0;
    localparam mode_t MODE_BIT4 = 2'd1;
    localparam mode_t MODE_BIT8 = 2'd2;
    localparam mode_t MODE_RGB  = 2'd3;

    typedef logic [2:0] op_t;
    localparam op_t OP_WRITE  = 3'd0;
    localparam op_t OP_BIT1   = 3'd1;
    localparam op_t OP_BIT4   = 3'd2;
    localparam op_t OP_BIT8   = 3'd3;
    localparam op_t OP_DIRECT = 3'd4;

    localparam logic [7:0] HI_NIBBLE = 8'hF0;
    localparam logic [7:0] LO_NIBBLE = 8'h0F;

    // colour packing: blue [7:0], green [15:8], red [23:16]
    typedef struct packed {
        op_t         op;
        logic [7:0]  index;
        logic [23:0] colour;
        logic [3:0]  npix;
        logic        row_end;
    } job_t;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       last;
        logic       row_end;
    } pixel_t;

endpackage

`default_nettype wire

// ----- hdl/indexed_pixel_palette_expander_unit.sv -----
// Palette expander: turns palette writes and padded bitmap row bytes into
// 24-bit blue/green/red pixels, one output transaction per pixel.
// Input channel (in_valid/in_stall): kind selects a palette entry write or a
// source row byte. Output channel (out_valid/out_stall): one pixel, with
// last_of_run on the final pixel of a byte and row_end on the last of a row.
// Config channel (cfg_valid/cfg_ready, cfg_ready always high): index 0 sets
// the source depth, index 1 the row width; any write restarts the row.
// A byte passes through the job queue, the palette read stage and the output
// buffer before its first pixel shows on out_valid. The pixel engine emits one
// pixel per cycle unless a stalled output has filled the output buffer; a 1-bit
// byte gives up to 8 pixels, a 4-bit byte up to 2. The front takes one transaction
// per cycle into a 4-deep job queue and stalls only when that queue is full.
// Reset clears row position, queues and config (8-bit depth, width 1);
// palette contents are undefined until written; no clearing pass.
// A stalled output holds its pixel; up to two pixels wait in the output
// buffer while lookups for later pixels keep going until that buffer is full.
`default_nettype none

module indexed_pixel_palette_expander_unit #(
    parameter int PALETTE_DEPTH = 256,
    parameter int MAX_ROW_WIDTH = 4096
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           kind,
    input  wire logic [7:0]                     palette_index,
    input  wire logic [7:0]                     palette_blue,
    input  wire logic [7:0]                     palette_green,
    input  wire logic [7:0]                     palette_red,
    input  wire logic [7:0]                     source_byte,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [7:0]                          pixel_blue,
    output logic [7:0]                          pixel_green,
    output logic [7:0]                          pixel_red,
    output logic                                last_of_run,
    output logic                                row_end,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire ippe_pkg::cfg_idx_t             cfg_index,
    input  wire logic [ippe_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ippe_pkg::*;

    job_t q_data;
    job_t q_head;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_head_valid;

    assign cfg_ready = 1'b1;

    ippe_front #(
        .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .palette_index (palette_index),
        .palette_blue  (palette_blue),
        .palette_green (palette_green),
        .palette_red   (palette_red),
        .source_byte   (source_byte),
        .cfg_valid     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_data        (q_data)
    );

    ippe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_data),
        .pop        (q_pop),
        .head       (q_head),
        .head_valid (q_head_valid),
        .full       (q_full)
    );

    ippe_back #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (q_head),
        .head_valid  (q_head_valid),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_blue  (pixel_blue),
        .pixel_green (pixel_green),
        .pixel_red   (pixel_red),
        .last_of_run (last_of_run),
        .row_end     (row_end)
    );

endmodule

`default_nettype wire

// ----- hdl/ippe_queue.sv -----
`default_nettype none

module ippe_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire ippe_pkg::job_t push_data,
    input  wire logic          pop,
    output ippe_pkg::job_t     head,
    output logic               head_valid,
    output logic               full
);
    import ippe_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t               entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wptr_reg, wptr_next;
    logic [PTR_W-1:0]   rptr_reg, rptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign head       = entry_reg[rptr_reg];
    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));

    always_comb
    begin
        wptr_next  = push ? wptr_reg + PTR_W'(1) : wptr_reg;
        rptr_next  = pop ? rptr_reg + PTR_W'(1) : rptr_reg;
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/ippe_front.sv -----
`default_nettype none

module ippe_front #(
    parameter int MAX_ROW_WIDTH = 4096
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           kind,
    input  wire logic [7:0]                     palette_index,
    input  wire logic [7:0]                     palette_blue,
    input  wire logic [7:0]                     palette_green,
    input  wire logic [7:0]                     palette_red,
    input  wire logic [7:0]                     source_byte,
    input  wire logic                           cfg_valid,
    input  wire ippe_pkg::cfg_idx_t             cfg_index,
    input  wire logic [ippe_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           q_full,
    output logic                                q_push,
    output ippe_pkg::job_t                      q_data
);
    import ippe_pkg::*;

    localparam int CW = $clog2(MAX_ROW_WIDTH + 1);
    localparam int WW = (CW > ROW_WIDTH_W) ? CW : ROW_WIDTH_W;
    localparam int PW = $clog2(3 * MAX_ROW_WIDTH + 4);

    mode_t                  mode_reg, mode_next;
    logic [ROW_WIDTH_W-1:0] width_reg, width_next;
    logic [PW-1:0]          pos_reg, pos_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [15:0]            hold_reg, hold_next;
    logic [1:0]             phase_reg, phase_next;

    logic [CW-1:0] eff_w;
    logic [PW-1:0] w_ext;
    logic [PW-1:0] nbytes;
    logic [PW-1:0] padded;
    logic [PW-1:0] pos_inc;
    logic [CW-1:0] remaining;
    logic [3:0]    ppb;
    logic [3:0]    npix;
    logic          in_data;
    logic          accept;

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (width_reg == '0)
            eff_w = CW'(1);
        else if (WW'(width_reg) > WW'(MAX_ROW_WIDTH))
            eff_w = CW'(MAX_ROW_WIDTH);
        else
            eff_w = CW'(width_reg);

        w_ext = PW'(eff_w);
        unique case (mode_reg)
            MODE_BIT1: nbytes = (w_ext + PW'(7)) >> 3;
            MODE_BIT4: nbytes = (w_ext + PW'(1)) >> 1;
            MODE_BIT8: nbytes = w_ext;
            default:   nbytes = (w_ext << 1) + w_ext;
        endcase
        padded  = (nbytes + PW'(3)) & ~PW'(3);
        in_data = (pos_reg < nbytes);
        pos_inc = pos_reg + PW'(1);

        unique case (mode_reg)
            MODE_BIT1: ppb = 4'd8;
            MODE_BIT4: ppb = 4'd2;
            MODE_BIT8: ppb = 4'd1;
            default:   ppb = (phase_reg == 2'd2) ? 4'd1 : 4'd0;
        endcase

        remaining = eff_w - count_reg;
        if (!in_data)
            npix = 4'd0;
        else if (CW'(ppb) < remaining)
            npix = ppb;
        else
            npix = remaining[3:0];
    end

    // job for the back end
    always_comb
    begin
        q_data.index   = kind ? source_byte : palette_index;
        q_data.npix    = npix;
        q_data.row_end = (npix != 4'd0) && (CW'(npix) == remaining);
        if (!kind)
        begin
            q_data.op     = OP_WRITE;
            q_data.colour = {palette_red, palette_green, palette_blue};
        end
        else
        begin
            unique case (mode_reg)
                MODE_BIT1: q_data.op = OP_BIT1;
                MODE_BIT4: q_data.op = OP_BIT4;
                MODE_BIT8: q_data.op = OP_BIT8;
                default:   q_data.op = OP_DIRECT;
            endcase
            q_data.colour = {source_byte, hold_reg};
        end
        q_push = accept && (!kind || (npix != 4'd0));
    end

    always_comb
    begin
        mode_next  = mode_reg;
        width_next = width_reg;
        pos_next   = pos_reg;
        count_next = count_reg;
        hold_next  = hold_reg;
        phase_next = phase_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_DEPTH_MODE: mode_next  = mode_t'(cfg_data[1:0]);
                default:        width_next = cfg_data[ROW_WIDTH_W-1:0];
            endcase
            pos_next   = '0;
            count_next = '0;
            hold_next  = '0;
            phase_next = '0;
        end
        else if (accept && kind)
        begin
            count_next = count_reg + CW'(npix);
            if (in_data && (mode_reg == MODE_RGB))
            begin
                unique case (phase_reg)
                    2'd0:
                    begin
                        hold_next  = {8'h00, source_byte};
                        phase_next = 2'd1;
                    end
                    2'd1:
                    begin
                        hold_next  = {source_byte, hold_reg[7:0]};
                        phase_next = 2'd2;
                    end
                    default:
                    begin
                        hold_next  = '0;
                        phase_next = 2'd0;
                    end
                endcase
            end
            pos_next = pos_inc;
            if (pos_inc >= padded)
            begin
                pos_next   = '0;
                count_next = '0;
                hold_next  = '0;
                phase_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_BIT8;
            width_reg <= ROW_WIDTH_W'(1);
            pos_reg   <= '0;
            count_reg <= '0;
            hold_reg  <= '0;
            phase_reg <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            width_reg <= width_next;
            pos_reg   <= pos_next;
            count_reg <= count_next;
            hold_reg  <= hold_next;
            phase_reg <= phase_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/ippe_back.sv -----
`default_nettype none

module ippe_back #(
    parameter int PALETTE_DEPTH = 256
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire ippe_pkg::job_t head,
    input  wire logic       head_valid,
    output logic            pop,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      pixel_blue,
    output logic [7:0]      pixel_green,
    output logic [7:0]      pixel_red,
    output logic            last_of_run,
    output logic            row_end
);
    import ippe_pkg::*;

    localparam int AW  = $clog2(PALETTE_DEPTH);
    localparam int OPW = $clog2(OUT_DEPTH);
    localparam int OCW = $clog2(OUT_DEPTH + 1);

    logic [23:0]      pal_mem [PALETTE_DEPTH];

    logic [2:0]       k_reg, k_next;
    logic [7:0]       idx;
    logic             idx_oob;
    logic             is_write;
    logic             is_last;
    logic             can_issue;
    logic             issue;
    logic             out_pop;
    logic [OCW-1:0]   occ;

    // read stage
    logic             s1_valid_reg;
    logic             s1_direct_reg;
    logic             s1_oob_reg;
    logic [23:0]      s1_colour_reg;
    logic [23:0]      rd_data_reg;
    logic             s1_last_reg;
    logic             s1_row_end_reg;
    pixel_t           s1_pixel;

    // output skid queue
    pixel_t           ofifo_reg [OUT_DEPTH];
    logic [OPW-1:0]   owptr_reg, orptr_reg;
    logic [OCW-1:0]   ocount_reg;
    pixel_t           ohead;

    assign is_write  = (head.op == OP_WRITE);
    assign is_last   = ({1'b0, k_reg} == (head.npix - 4'd1));
    assign out_pop   = out_valid && !out_stall;
    assign occ       = ocount_reg + OCW'(s1_valid_reg);
    assign can_issue = (occ < OCW'(OUT_DEPTH)) || out_pop;
    assign issue     = head_valid && !is_write && can_issue;
    assign pop       = head_valid && (is_write || (issue && is_last));
    assign idx_oob   = ({1'b0, idx} >= 9'(PALETTE_DEPTH));

    always_comb
    begin
        unique case (head.op)
            OP_BIT1: idx = {7'd0, head.index[3'd7 - k_reg]};
            OP_BIT4: idx = (k_reg == 3'd0) ? ((head.index & HI_NIBBLE) >> 4)
                                           : (head.index & LO_NIBBLE);
            OP_BIT8: idx = head.index;
            default: idx = 8'd0;
        endcase

        if (pop)
            k_next = 3'd0;
        else if (issue)
            k_next = k_reg + 3'd1;
        else
            k_next = k_reg;
    end

    always_ff @(posedge clk)
    begin
        if (head_valid && is_write && ({1'b0, head.index} < 9'(PALETTE_DEPTH)))
        begin
            pal_mem[head.index[AW-1:0]] <= head.colour;
        end
        if (issue)
        begin
            rd_data_reg <= pal_mem[idx[AW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_direct_reg  <= (head.op == OP_DIRECT);
            s1_oob_reg     <= idx_oob;
            s1_colour_reg  <= head.colour;
            s1_last_reg    <= is_last;
            s1_row_end_reg <= is_last && head.row_end;
        end
    end

    always_comb
    begin
        if (s1_direct_reg)
            {s1_pixel.red, s1_pixel.green, s1_pixel.blue} = s1_colour_reg;
        else if (s1_oob_reg)
            {s1_pixel.red, s1_pixel.green, s1_pixel.blue} = 24'd0;
        else
            {s1_pixel.red, s1_pixel.green, s1_pixel.blue} = rd_data_reg;
        s1_pixel.last    = s1_last_reg;
        s1_pixel.row_end = s1_row_end_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            ofifo_reg[owptr_reg] <= s1_pixel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg        <= '0;
            s1_valid_reg <= 1'b0;
            owptr_reg    <= '0;
            orptr_reg    <= '0;
            ocount_reg   <= '0;
        end
        else
        begin
            k_reg        <= k_next;
            s1_valid_reg <= issue;
            if (s1_valid_reg)
                owptr_reg <= owptr_reg + OPW'(1);
            if (out_pop)
                orptr_reg <= orptr_reg + OPW'(1);
            ocount_reg <= ocount_reg + OCW'(s1_valid_reg) - OCW'(out_pop);
        end
    end

    assign ohead       = ofifo_reg[orptr_reg];
    assign out_valid   = (ocount_reg != '0);
    assign pixel_blue  = ohead.blue;
    assign pixel_green = ohead.green;
    assign pixel_red   = ohead.red;
    assign last_of_run = ohead.last;
    assign row_end     = ohead.row_end;

endmodule

`default_nettype wire

// ----- hdl/ippe_checker.sv -----
`default_nettype none

`include "indexed_pixel_palette_expander_unit_assert.svh"

module ippe_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] pixel_blue,
    input wire logic [7:0] pixel_green,
    input wire logic [7:0] pixel_red,
    input wire logic       last_of_run,
    input wire logic       row_end
);

    // a held pixel stays put
    `IPPE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(pixel_blue) && $stable(pixel_green) && $stable(pixel_red) && $stable(last_of_run) && $stable(row_end), "stalled pixel changed")

    // the row always closes on the final pixel of a byte
    `IPPE_ASSERT_NOW(a_row_end_last, out_valid && row_end, last_of_run, "row end not on last pixel of its byte")

    // the job queue only fills by taking a transaction
    `IPPE_ASSERT_NOW(a_stall_cause, $rose(in_stall), $past(in_valid && !in_stall), "input stall without a prior transaction")

    // output drops only after a transaction leaves
    `IPPE_ASSERT_NOW(a_out_drop, $fell(out_valid), $past(!out_stall), "output valid dropped while stalled")

endmodule

bind indexed_pixel_palette_expander_unit ippe_checker u_ippe_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_blue  (pixel_blue),
    .pixel_green (pixel_green),
    .pixel_red   (pixel_red),
    .last_of_run (last_of_run),
    .row_end     (row_end)
);

`default_nettype wire
